FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: status codes,
// the result item and the bundle of up to three results one byte can cause.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_OUT_BYTES_DEF = 32768;
    localparam int CAP_W             = 16;
    localparam int LEN_W             = 15;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int MAX_RESULTS       = 3;

    // Register index on the configuration port.
    localparam logic [0:0] REG_OUT_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET  = 16'h8000;

    typedef enum logic [2:0] {
        ST_DATA         = 3'd0,
        ST_DONE         = 3'd1,
        ST_NO_QUOTE     = 3'd2,
        ST_UNTERMINATED = 3'd3,
        ST_OVERFLOW     = 3'd4,
        ST_BAD_ESCAPE   = 3'd5,
        ST_BAD_HEX      = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0]       data;
        status_t          status;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } bundle_t;

endpackage

FILE: design/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Input register, parser state and the single-pass decode of one byte into
// a bundle of zero to three result items.
// ----------------------------------------------------------------------------
module jsu_decode #(
    parameter int MAX_OUT_BYTES = jsu_pkg::MAX_OUT_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        start_of_string,
    input  logic [jsu_pkg::CAP_W-1:0]   out_capacity,
    input  logic                        load_ok,
    output logic                        res_load,
    output jsu_pkg::bundle_t            bundle
);
    import jsu_pkg::*;

    localparam int CAP_LIMIT = (MAX_OUT_BYTES < 32768) ? MAX_OUT_BYTES : 32768;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_U         = 8'h75;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_STRING = 4'b0010,
        PH_ESCAPE = 4'b0100,
        PH_HEX    = 4'b1000
    } phase_t;

    logic             item_valid_reg, item_valid_next;
    logic [7:0]       item_byte_reg;
    logic             item_start_reg;
    phase_t           phase_reg, phase_next;
    logic [2:0]       hex_seen_reg, hex_seen_next;
    logic [15:0]      code_point_reg, code_point_next;
    logic [LEN_W-1:0] written_reg, written_next;

    logic             advance;
    logic             accept;
    logic [CAP_W-1:0] eff_cap;

    // Returns the digit value in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    assign advance  = item_valid_reg && load_ok;
    assign in_stall = item_valid_reg && !load_ok;
    assign accept   = in_valid && !in_stall;
    assign res_load = advance && (bundle.count != 2'd0);

    assign eff_cap = (out_capacity > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : out_capacity;

    always_comb
    begin
        logic [16:0] w_ext;
        logic        room1, room2, room3;
        logic [7:0]  esc;
        logic        esc_ok;
        logic [4:0]  hd;
        logic [15:0] cp;
        logic [7:0]  c;

        c      = item_byte_reg;
        w_ext  = {2'b00, written_reg};
        room1  = (w_ext + 17'd1) < {1'b0, eff_cap};
        room2  = (w_ext + 17'd2) < {1'b0, eff_cap};
        room3  = (w_ext + 17'd3) < {1'b0, eff_cap};
        hd     = hex_digit(c);
        cp     = {code_point_reg[11:0], hd[3:0]};
        esc    = 8'h00;
        esc_ok = 1'b1;
        case (c)
            CH_QUOTE:     esc = CH_QUOTE;
            CH_BACKSLASH: esc = CH_BACKSLASH;
            CH_SLASH:     esc = CH_SLASH;
            CH_N:         esc = 8'h0A;
            CH_R:         esc = 8'h0D;
            CH_T:         esc = 8'h09;
            CH_B:         esc = 8'h08;
            CH_F:         esc = 8'h0C;
            default:      esc_ok = 1'b0;
        endcase

        phase_next      = phase_reg;
        hex_seen_next   = hex_seen_reg;
        code_point_next = code_point_reg;
        written_next    = written_reg;
        bundle          = '0;

        if (item_start_reg) begin
            written_next    = '0;
            hex_seen_next   = '0;
            code_point_next = '0;
            if (c != CH_QUOTE) begin
                phase_next            = PH_IDLE;
                bundle.count          = 2'd1;
                bundle.res[0].status  = ST_NO_QUOTE;
                bundle.res[0].last    = 1'b1;
            end else begin
                phase_next = PH_STRING;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_STRING:
                begin
                    bundle.res[0].length = written_reg;
                    bundle.res[0].last   = 1'b1;
                    if (c == CH_NUL || c == CH_QUOTE || !room1) begin
                        phase_next           = PH_IDLE;
                        hex_seen_next        = '0;
                        code_point_next      = '0;
                        bundle.count         = 2'd1;
                        bundle.res[0].status = (c == CH_NUL)   ? ST_UNTERMINATED :
                                               (c == CH_QUOTE) ? ST_DONE : ST_OVERFLOW;
                    end else if (c == CH_BACKSLASH) begin
                        phase_next = PH_ESCAPE;
                    end else begin
                        written_next         = written_reg + 1'b1;
                        bundle.count         = 2'd1;
                        bundle.res[0].data   = c;
                        bundle.res[0].status = ST_DATA;
                        bundle.res[0].length = written_reg + 1'b1;
                    end
                end
                PH_ESCAPE:
                begin
                    bundle.res[0].last = 1'b1;
                    if (esc_ok) begin
                        phase_next           = PH_STRING;
                        written_next         = written_reg + 1'b1;
                        bundle.count         = 2'd1;
                        bundle.res[0].data   = esc;
                        bundle.res[0].status = ST_DATA;
                        bundle.res[0].length = written_reg + 1'b1;
                    end else if (c == CH_U) begin
                        phase_next      = PH_HEX;
                        hex_seen_next   = '0;
                        code_point_next = '0;
                    end else begin
                        phase_next           = PH_IDLE;
                        hex_seen_next        = '0;
                        code_point_next      = '0;
                        bundle.count         = 2'd1;
                        bundle.res[0].status = ST_BAD_ESCAPE;
                        bundle.res[0].length = written_reg;
                    end
                end
                PH_HEX:
                begin
                    if (c == CH_NUL || !hd[4]) begin
                        phase_next           = PH_IDLE;
                        hex_seen_next        = '0;
                        code_point_next      = '0;
                        bundle.count         = 2'd1;
                        bundle.res[0].status = (c == CH_NUL) ? ST_UNTERMINATED : ST_BAD_HEX;
                        bundle.res[0].length = written_reg;
                        bundle.res[0].last   = 1'b1;
                    end else if (hex_seen_reg < 3'd3) begin
                        code_point_next = cp;
                        hex_seen_next   = hex_seen_reg + 3'd1;
                    end else begin
                        // Fourth digit: emit the code point as UTF-8, or report overflow if it does not fit.
                        hex_seen_next   = '0;
                        code_point_next = '0;
                        phase_next      = PH_STRING;
                        bundle.res[0].length = written_reg + 15'd1;
                        bundle.res[1].length = written_reg + 15'd2;
                        bundle.res[2].length = written_reg + 15'd3;
                        if (cp < 16'h0080) begin
                            if (room1) begin
                                written_next       = written_reg + 15'd1;
                                bundle.count       = 2'd1;
                                bundle.res[0].data = cp[7:0];
                                bundle.res[0].last = 1'b1;
                            end
                        end else if (cp < 16'h0800) begin
                            if (room2) begin
                                written_next       = written_reg + 15'd2;
                                bundle.count       = 2'd2;
                                bundle.res[0].data = {3'b110, cp[10:6]};
                                bundle.res[1].data = {2'b10, cp[5:0]};
                                bundle.res[1].last = 1'b1;
                            end
                        end else begin
                            if (room3) begin
                                written_next       = written_reg + 15'd3;
                                bundle.count       = 2'd3;
                                bundle.res[0].data = {4'b1110, cp[15:12]};
                                bundle.res[1].data = {2'b10, cp[11:6]};
                                bundle.res[2].data = {2'b10, cp[5:0]};
                                bundle.res[2].last = 1'b1;
                            end
                        end
                        if (bundle.count == 2'd0) begin
                            phase_next           = PH_IDLE;
                            bundle.count         = 2'd1;
                            bundle.res[0].status = ST_OVERFLOW;
                            bundle.res[0].length = written_reg;
                            bundle.res[0].last   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept) item_valid_next = 1'b1;
        else if (advance) item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            hex_seen_reg   <= '0;
            code_point_reg <= '0;
            written_reg    <= '0;
        end else begin
            item_valid_reg <= item_valid_next;
            if (advance) begin
                phase_reg      <= phase_next;
                hex_seen_reg   <= hex_seen_next;
                code_point_reg <= code_point_next;
                written_reg    <= written_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_byte_reg  <= in_byte;
            item_start_reg <= start_of_string;
        end
    end

endmodule

FILE: design/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register: holds the bundle of one decoded byte and hands its
// results out one beat at a time.
// ----------------------------------------------------------------------------
module jsu_outbuf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_load,
    input  jsu_pkg::bundle_t             bundle,
    output logic                         load_ok,
    output logic                         out_valid,
    input  logic                         out_stall,
    output jsu_pkg::result_t             result
);
    import jsu_pkg::*;

    result_t    slot_reg [MAX_RESULTS];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && !out_stall;
    // A new bundle may land when the buffer is empty or its final beat leaves now.
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);
    assign result    = slot_reg[idx_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (res_load) begin
            cnt_next = bundle.count;
            idx_next = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load) begin
            slot_reg[0] <= bundle.res[0];
            slot_reg[1] <= bundle.res[1];
            slot_reg[2] <= bundle.res[2];
        end
    end

endmodule

FILE: design/json_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// Unescapes a quoted JSON string byte by byte into raw and UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry in_byte and start_of_string; a byte
// with start_of_string set opens a new string and must be a double quote.
// Output channel: out_valid/out_stall carry out_byte, status, decoded_length
// and last. Each input byte gives zero to three result beats; last marks the
// final beat of a byte. Data beats have status 0, a string ends in one done
// or error beat, and bytes after that are dropped until the next start.
// An accepted byte passes the input register, then the result register, before its first result beat.
// Throughput is one byte per cycle while the receiver does not stall; a \u escape
// that expands to two or three UTF-8 bytes holds the input while the result
// register drains, one beat per cycle.
// out_capacity (APB, address 0) limits the decoded length, one byte kept for
// the terminator; write it only while the block is idle. Reset empties the
// pipeline, returns the parser to idle and sets out_capacity to 32768. When
// the receiver stalls, the current beat holds and the input stalls as soon
// as the input register and result register are both occupied.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit #(
    parameter int MAX_OUT_BYTES = jsu_pkg::MAX_OUT_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         in_byte,
    input  logic                               start_of_string,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         out_byte,
    output logic [2:0]                         status,
    output logic [jsu_pkg::LEN_W-1:0]          decoded_length,
    output logic                               last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jsu_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [jsu_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [jsu_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import jsu_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             cap_sel;
    logic             load_ok;
    logic             res_load;
    bundle_t          bundle;
    result_t          result;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[CFG_ADDR_W-1:2] == REG_OUT_CAPACITY);
    assign prdata  = cap_sel ? {{(CFG_DATA_W-CAP_W){1'b0}}, capacity_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && cap_sel) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    jsu_decode #(
        .MAX_OUT_BYTES (MAX_OUT_BYTES)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .start_of_string (start_of_string),
        .out_capacity    (capacity_reg),
        .load_ok         (load_ok),
        .res_load        (res_load),
        .bundle          (bundle)
    );

    jsu_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .bundle    (bundle),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign out_byte       = result.data;
    assign status         = result.status;
    assign decoded_length = result.length;
    assign last           = result.last;

endmodule

FILE: test/json_string_unescaper_unit_tb.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_unit_tb
// Drives quoted JSON strings into the unescaper and predicts every result
// beat: decoded bytes, UTF-8 expansion of \u escapes, the done beat and each
// error status. A short table covers the corner cases first. Random strings
// with random escapes follow, mixed with broken and stray input, over a range
// of out_capacity settings. Both channels idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BEATS    = 11;
    localparam int EFF_CAP_MAX    = MAX_OUT_BYTES_DEF < 32768 ? MAX_OUT_BYTES_DEF : 32768;

    localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = CFG_ADDR_W'(4 * REG_OUT_CAPACITY);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, "/", "n", "r", "t", "b", "f"};
    localparam logic [15:0] CP_EDGES [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                             16'h0800, 16'hFFFF};
    localparam int NUM_PHASES = 8;
    localparam logic [15:0] CAP_PLAN [NUM_PHASES] = '{16'd1, 16'd0, 16'd3, 16'd8, 16'd65535,
                                                      16'd2, 16'd20, 16'd32768};
    localparam int PRESSURE_PHASE = 4;
    localparam int STEADY_PHASE   = 7;

    typedef enum logic [1:0] {PH_IDLE, PH_STRING, PH_ESCAPE, PH_HEX} parse_phase_t;

    typedef struct packed {
        logic [7:0]       ch;
        logic             sos;
        logic             typed;
        status_t          st;
        logic [LEN_W-1:0] len;
    } corner_row_t;

    // Written with out_capacity = 5, so at most four bytes fit.
    localparam int CORNER_ROWS = 34;
    localparam corner_row_t CORNER_TABLE [CORNER_ROWS] = '{
        '{"x",       1'b1, 1'b1, ST_NO_QUOTE,     15'd0},
        '{"A",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{8'hFF,     1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_BSLASH, 1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_U,      1'b0, 1'b0, ST_DATA,         15'd0},
        '{"0",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"0",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"0",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"0",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_BSLASH, 1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_U,      1'b0, 1'b0, ST_DATA,         15'd0},
        '{"F",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"f",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"f",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{"f",       1'b0, 1'b1, ST_OVERFLOW,     15'd2},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{CH_BSLASH, 1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_NUL,    1'b0, 1'b1, ST_BAD_ESCAPE,   15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{CH_BSLASH, 1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_U,      1'b0, 1'b0, ST_DATA,         15'd0},
        '{"1",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_NUL,    1'b0, 1'b1, ST_UNTERMINATED, 15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{"A",       1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{CH_BSLASH, 1'b0, 1'b0, ST_DATA,         15'd0},
        '{CH_U,      1'b0, 1'b0, ST_DATA,         15'd0},
        '{"g",       1'b0, 1'b1, ST_BAD_HEX,      15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{CH_NUL,    1'b0, 1'b1, ST_UNTERMINATED, 15'd0},
        '{CH_QUOTE,  1'b1, 1'b0, ST_DATA,         15'd0},
        '{CH_QUOTE,  1'b0, 1'b1, ST_DONE,         15'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            in_byte = 8'h00;
    logic                  start_of_string = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            out_byte;
    logic [2:0]            status;
    logic [LEN_W-1:0]      decoded_length;
    logic                  last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state.
    parse_phase_t     parse_phase = PH_IDLE;
    logic [2:0]       hex_seen = '0;
    logic [15:0]      cp_acc = '0;
    logic [LEN_W-1:0] written = '0;
    logic [CAP_W-1:0] capacity_reg = CAP_RESET;
    result_t          step_out [MAX_RESULTS];
    int               step_n;

    result_t decoded_due [$];
    result_t want_beat;
    int      mismatches = 0;
    int      beats_sent = 0;
    int      quiet_cycles = 0;
    int      holds_asked = 0;
    int      holds_done = 0;
    bit      tx_gaps = 1'b1;
    bit      rx_gaps = 1'b1;

    json_string_unescaper_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .start_of_string (start_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .status          (status),
        .decoded_length  (decoded_length),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_beat(input logic [7:0] ch, input status_t st);
        step_out[step_n] = '{data: ch, status: st, length: written, last: 1'b0};
        step_n++;
    endfunction

    function automatic void emit_byte(input logic [7:0] ch);
        written = written + 1'b1;
        put_beat(ch, ST_DATA);
    endfunction

    function automatic void end_string(input status_t st);
        put_beat(8'h00, st);
        parse_phase = PH_IDLE;
        hex_seen = '0;
        cp_acc = '0;
    endfunction

    // One byte of every destination is kept for the terminator.
    function automatic bit has_room(input int k);
        int cap;
        cap = int'(capacity_reg) > EFF_CAP_MAX ? EFF_CAP_MAX : int'(capacity_reg);
        return int'(written) + k < cap;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void unescape_step(input logic [7:0] c, input logic sos);
        logic [7:0]  mapped;
        bit          escaped;
        int          nib;
        logic [15:0] cp;
        step_n = 0;
        if (sos) begin
            written = '0;
            hex_seen = '0;
            cp_acc = '0;
            if (c != CH_QUOTE)
                end_string(ST_NO_QUOTE);
            else
                parse_phase = PH_STRING;
        end
        else begin
            case (parse_phase)
                PH_STRING:
                begin
                    if (c == CH_NUL)
                        end_string(ST_UNTERMINATED);
                    else if (c == CH_QUOTE)
                        end_string(ST_DONE);
                    else if (!has_room(1))
                        end_string(ST_OVERFLOW);
                    else if (c == CH_BSLASH)
                        parse_phase = PH_ESCAPE;
                    else
                        emit_byte(c);
                end
                PH_ESCAPE:
                begin
                    escaped = 1'b1;
                    mapped = 8'h00;
                    case (c)
                        CH_QUOTE:  mapped = CH_QUOTE;
                        CH_BSLASH: mapped = CH_BSLASH;
                        "/":       mapped = "/";
                        "n":       mapped = 8'h0A;
                        "r":       mapped = 8'h0D;
                        "t":       mapped = 8'h09;
                        "b":       mapped = 8'h08;
                        "f":       mapped = 8'h0C;
                        default:   escaped = 1'b0;
                    endcase
                    if (escaped)
                    begin
                        parse_phase = PH_STRING;
                        emit_byte(mapped);
                    end
                    else if (c == CH_U)
                    begin
                        parse_phase = PH_HEX;
                        hex_seen = '0;
                        cp_acc = '0;
                    end
                    else
                        end_string(ST_BAD_ESCAPE);
                end
                PH_HEX:
                begin
                    nib = hex_digit(c);
                    if (c == CH_NUL)
                        end_string(ST_UNTERMINATED);
                    else if (nib < 0)
                        end_string(ST_BAD_HEX);
                    else
                    begin
                        cp_acc = {cp_acc[11:0], 4'(nib)};
                        hex_seen = hex_seen + 1'b1;
                        if (hex_seen >= 3'd4)
                        begin
                            cp = cp_acc;
                            hex_seen = '0;
                            cp_acc = '0;
                            parse_phase = PH_STRING;
                            // The overflow check covers the whole UTF-8 sequence at once.
                            if (cp < 16'h0080)
                            begin
                                if (!has_room(1))
                                    end_string(ST_OVERFLOW);
                                else
                                    emit_byte(cp[7:0]);
                            end
                            else if (cp < 16'h0800)
                            begin
                                if (!has_room(2))
                                    end_string(ST_OVERFLOW);
                                else
                                begin
                                    emit_byte({3'b110, cp[10:6]});
                                    emit_byte({2'b10, cp[5:0]});
                                end
                            end
                            else
                            begin
                                if (!has_room(3))
                                    end_string(ST_OVERFLOW);
                                else
                                begin
                                    emit_byte({4'b1110, cp[15:12]});
                                    emit_byte({2'b10, cp[11:6]});
                                    emit_byte({2'b10, cp[5:0]});
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (step_n > 0)
            step_out[step_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] ch, input logic sos, input logic typed = 1'b0,
                             input status_t st = ST_DATA, input logic [LEN_W-1:0] len = '0);
        while (tx_gaps && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= ch;
        start_of_string <= sos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        unescape_step(ch, sos);
        if (typed)
            decoded_due.push_back('{data: 8'h00, status: st, length: len, last: 1'b1});
        else
            for (int i = 0; i < step_n; i++)
                decoded_due.push_back(step_out[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [15:0] random_code_point();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 'h7F));
            1:       return 16'($urandom_range('h80, 'h7FF));
            2:       return 16'($urandom_range('h800, 'hFFFF));
            3:       return 16'($urandom_range('hD800, 'hDFFF));
            default: return CP_EDGES[$urandom_range(0, 5)];
        endcase
    endfunction

    task automatic send_unicode_escape();
        logic [15:0] cp;
        cp = random_code_point();
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_beat(hex_char(cp[4*i +: 4]), 1'b0);
    endtask

    task automatic send_json_string();
        int kind;
        send_beat(CH_QUOTE, 1'b1);
        repeat ($urandom_range(0, 5))
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                send_beat(plain_byte(), 1'b0);
            else if (kind < 7)
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
            end
            else
                send_unicode_escape();
        end
        send_beat(CH_QUOTE, 1'b0);
    endtask

    // Stray bytes, strings cut short by a NUL, odd escapes, short hex runs and
    // strings that the next start simply abandons.
    task automatic send_broken_string();
        case ($urandom_range(0, 4))
            0: send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            1:
            begin
                send_beat(CH_QUOTE, 1'b1);
                repeat ($urandom_range(0, 3))
                    send_beat(plain_byte(), 1'b0);
                send_beat(CH_NUL, 1'b0);
            end
            2:
            begin
                send_beat(CH_QUOTE, 1'b1);
                send_beat(CH_BSLASH, 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            3:
            begin
                send_beat(CH_QUOTE, 1'b1);
                send_beat(CH_BSLASH, 1'b0);
                send_beat(CH_U, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            default:
            begin
                send_beat(CH_QUOTE, 1'b1);
                repeat ($urandom_range(0, 3))
                    send_beat(plain_byte(), 1'b0);
            end
        endcase
    endtask

    // Lets the block run dry; a byte that gives no beat may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CAP_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_capacity(input logic [CAP_W-1:0] want);
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[CAP_W-1:0] !== want)
            report_mismatch("out_capacity readback", 32'(rd[CAP_W-1:0]), 32'(want));
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b1, CFG_DATA_W'(value), rd);
        capacity_reg = value;
        check_capacity(value);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
                holds_done++;
            end
            else
                out_stall <= rx_gaps && ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_due.size() == 0)
                report_mismatch("beat with nothing pending, status", 32'(status), 32'd0);
            else
            begin
                want_beat = decoded_due.pop_front();
                if (out_byte !== want_beat.data)
                    report_mismatch("out_byte", 32'(out_byte), 32'(want_beat.data));
                if (status !== want_beat.status)
                    report_mismatch("status", 32'(status), 32'(want_beat.status));
                if (decoded_length !== want_beat.length)
                    report_mismatch("decoded_length", 32'(decoded_length),
                                    32'(want_beat.length));
                if (last !== want_beat.last)
                    report_mismatch("last", 32'(last), 32'(want_beat.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("json_string_unescaper_unit_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_capacity(CAP_RESET);

        set_capacity(16'd5);
        for (int r = 0; r < CORNER_ROWS; r++)
            send_beat(CORNER_TABLE[r].ch, CORNER_TABLE[r].sos, CORNER_TABLE[r].typed,
                      CORNER_TABLE[r].st, CORNER_TABLE[r].len);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            set_capacity(CAP_PLAN[p]);
            tx_gaps = !(p == PRESSURE_PHASE || p == STEADY_PHASE);
            rx_gaps = tx_gaps;
            // The receiver holds off while bytes keep coming, so the block backs up.
            if (p == PRESSURE_PHASE)
                holds_asked++;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                if ($urandom_range(0, 99) < 80)
                    send_json_string();
                else
                    send_broken_string();
            end
        end

        settle();
        if (mismatches == 0)
            $display("json_string_unescaper_unit_tb OK");
        else
            $display("json_string_unescaper_unit_tb NOT OK");
        $finish;
    end

endmodule

FILE: json_string_unescaper_unit.f
design/jsu_pkg.sv
design/jsu_decode.sv
design/jsu_outbuf.sv
design/json_string_unescaper_unit.sv
test/json_string_unescaper_unit_tb.sv
